### hdl/dlrp_pkg.sv
package dlrp_pkg;

    localparam int POOL_DEPTH = 128;
    localparam int POS_W      = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;

    localparam int SEED_W   = 32;
    localparam int CACHE_W  = 15;
    localparam int VALUE_W  = 7;
    localparam int OFFSET_W = 7;
    localparam int OP_W     = 2;

    // wide enough for pos + offset before reduction
    localparam int SUM_W = $clog2(POOL_DEPTH + (1 << OFFSET_W) - 1);

    localparam int LFSR_STEPS = 31;
    localparam int STEP_W     = $clog2(LFSR_STEPS);
    localparam int TOP_BIT    = 30;

    localparam logic [SEED_W-1:0] SEED_A_RESET = 32'h5465_7687;
    localparam logic [SEED_W-1:0] SEED_B_RESET = 32'h7264_1663;

    localparam logic [OP_W-1:0] OP_NEXT = 2'd0;
    localparam logic [OP_W-1:0] OP_FILL = 2'd1;
    localparam logic [OP_W-1:0] OP_LOAD = 2'd2;
    localparam logic [OP_W-1:0] OP_READ = 2'd3;

    localparam int S_DATA_W = 72;
    localparam int M_DATA_W = 48;

endpackage

### hdl/dual_lfsr_random_pool_unit.sv
// channel   dir  handshake                  payload
// s (item)  in   i_s_tvalid / o_s_tready    s_tdata: seed_a, seed_b, offset; s_tuser: op
// m (item)  out  o_m_tvalid / i_m_tready    m_tdata: rand_a, rand_b, pool_value, pool_pos
//
// one item at a time; both seeds share one shift step per cycle
// next: ring write, 31 seed steps, handoff; fill: write and steps per entry, handoff
// load: seeds and caches taken at accept, then handoff; read: reduce, read wait, handoff
// after reset a clearing pass writes zero to every ring entry, not ready meanwhile
// a finished item waits in the output register; a stall holds only the final handoff
module dual_lfsr_random_pool_unit
    import dlrp_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    // [31:0] seed_a, [63:32] seed_b, [70:64] offset, [71] zero
    input  logic [S_DATA_W-1:0] i_s_tdata,
    // [1:0] op
    input  logic [OP_W-1:0]     i_s_tuser,
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    // [14:0] rand_a, [29:15] rand_b, [36:30] pool_value, [43:37] pool_pos, [47:44] zero
    output logic [M_DATA_W-1:0] o_m_tdata
);

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_WRITE  = 3'd2;
    localparam logic [2:0] ST_STEP   = 3'd3;
    localparam logic [2:0] ST_REDUCE = 3'd4;
    localparam logic [2:0] ST_RWAIT  = 3'd5;
    localparam logic [2:0] ST_DONE   = 3'd6;

    function automatic logic [SEED_W-1:0] lfsr_step(input logic [SEED_W-1:0] s);
        logic [SEED_W-1:0] t;
        t = s >> 1;
        t[TOP_BIT] = t[TOP_BIT] | (s[0] ^ s[4]);
        return t;
    endfunction

    logic [2:0]          r_state, n_state;
    logic [OP_W-1:0]     r_op, n_op;
    logic [SEED_W-1:0]   r_seed_a, n_seed_a;
    logic [SEED_W-1:0]   r_seed_b, n_seed_b;
    logic [CACHE_W-1:0]  r_cache_a, n_cache_a;
    logic [CACHE_W-1:0]  r_cache_b, n_cache_b;
    logic [POS_W-1:0]    r_pos, n_pos;
    logic [POS_W-1:0]    r_cnt, n_cnt;
    logic [STEP_W-1:0]   r_step, n_step;
    logic [SUM_W-1:0]    r_idx, n_idx;
    logic                r_out_valid, n_out_valid;
    logic [M_DATA_W-1:0] r_out_data, n_out_data;

    logic                s_accept;
    logic                ram_we;
    logic [POS_W-1:0]    ram_waddr;
    logic [VALUE_W-1:0]  ram_wdata;
    logic [VALUE_W-1:0]  ram_rdata;
    logic [SEED_W-1:0]   step_a, step_b;
    logic [POS_W-1:0]    pos_inc;
    logic [VALUE_W-1:0]  out_value;

    assign o_s_tready = (r_state == ST_IDLE);
    assign s_accept   = i_s_tvalid && o_s_tready;

    assign step_a  = lfsr_step(r_seed_a);
    assign step_b  = lfsr_step(r_seed_b);
    assign pos_inc = (r_pos == POS_W'(POOL_DEPTH - 1)) ? '0 : r_pos + 1'b1;

    assign ram_we    = (r_state == ST_CLEAR) || (r_state == ST_WRITE);
    assign ram_waddr = (r_state == ST_CLEAR) ? r_cnt : r_pos;
    assign ram_wdata = (r_state == ST_CLEAR) ? '0 : r_cache_a[VALUE_W-1:0];
    assign out_value = (r_op == OP_READ) ? ram_rdata : '0;

    dlrp_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (POOL_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_idx[POS_W-1:0]),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_seed_a    = r_seed_a;
        n_seed_b    = r_seed_b;
        n_cache_a   = r_cache_a;
        n_cache_b   = r_cache_b;
        n_pos       = r_pos;
        n_cnt       = r_cnt;
        n_step      = r_step;
        n_idx       = r_idx;
        n_out_valid = r_out_valid && !i_m_tready;
        n_out_data  = r_out_data;

        case (r_state)
            ST_CLEAR: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == POS_W'(POOL_DEPTH - 1)) begin
                    n_cnt   = '0;
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_accept) begin
                    n_op = i_s_tuser;
                    case (i_s_tuser)
                        OP_NEXT: begin
                            n_state = ST_WRITE;
                        end
                        OP_FILL: begin
                            n_pos   = '0;
                            n_cnt   = '0;
                            n_state = ST_WRITE;
                        end
                        OP_LOAD: begin
                            n_seed_a  = i_s_tdata[31:0];
                            n_seed_b  = i_s_tdata[63:32];
                            n_cache_a = i_s_tdata[CACHE_W-1:0];
                            n_cache_b = i_s_tdata[32 +: CACHE_W];
                            n_state   = ST_DONE;
                        end
                        default: begin
                            n_idx   = SUM_W'(r_pos) + SUM_W'(i_s_tdata[70:64]);
                            n_state = ST_REDUCE;
                        end
                    endcase
                end
            end
            ST_WRITE: begin
                n_pos   = pos_inc;
                n_step  = '0;
                n_state = ST_STEP;
            end
            ST_STEP: begin
                n_seed_a = step_a;
                n_seed_b = step_b;
                n_step   = r_step + 1'b1;
                if (r_step == STEP_W'(LFSR_STEPS - 1)) begin
                    n_cache_a = step_a[CACHE_W-1:0];
                    n_cache_b = step_b[CACHE_W-1:0];
                    if (r_op == OP_FILL && r_cnt != POS_W'(POOL_DEPTH - 1)) begin
                        n_cnt   = r_cnt + 1'b1;
                        n_state = ST_WRITE;
                    end else begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_REDUCE: begin
                // one subtract a cycle until the index lands inside the ring
                if (r_idx >= SUM_W'(POOL_DEPTH)) begin
                    n_idx = r_idx - SUM_W'(POOL_DEPTH);
                end else begin
                    n_state = ST_RWAIT;
                end
            end
            ST_RWAIT: begin
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (!r_out_valid || i_m_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {4'b0, 7'(r_pos), out_value, r_cache_b, r_cache_a};
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_op        <= OP_NEXT;
            r_seed_a    <= SEED_A_RESET;
            r_seed_b    <= SEED_B_RESET;
            r_cache_a   <= '0;
            r_cache_b   <= '0;
            r_pos       <= '0;
            r_cnt       <= '0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_op        <= n_op;
            r_seed_a    <= n_seed_a;
            r_seed_b    <= n_seed_b;
            r_cache_a   <= n_cache_a;
            r_cache_b   <= n_cache_b;
            r_pos       <= n_pos;
            r_cnt       <= n_cnt;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_out_data <= n_out_data;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    a_pos_in_ring: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos < POS_W'(POOL_DEPTH - 1) || r_pos == POS_W'(POOL_DEPTH - 1))
        else $error("ring position beyond pool depth");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept |=> !o_s_tready)
        else $error("ready again right after an item was taken");

    a_step_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_STEP) |-> (r_step < STEP_W'(LFSR_STEPS)))
        else $error("seed step count overran");

    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE || r_state == ST_DONE) |-> !ram_we)
        else $error("ring written outside next, fill or clearing");

    a_read_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RWAIT) |-> (r_idx < SUM_W'(POOL_DEPTH)))
        else $error("read index not reduced into the ring");

endmodule

### hdl/dlrp_ram.sv
module dlrp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### verif/tb_dual_lfsr_random_pool_unit.sv
module tb_dual_lfsr_random_pool_unit;
    import dlrp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [CACHE_W-1:0] rand_a;
        logic [CACHE_W-1:0] rand_b;
        logic [VALUE_W-1:0] pool_value;
        logic [6:0]         pool_pos;
    } pool_result_t;

    // tracks the seed, cache and ring state and queues the result of each item
    class pool_scoreboard;
        logic [SEED_W-1:0]  seed_a_q;
        logic [SEED_W-1:0]  seed_b_q;
        logic [CACHE_W-1:0] cache_a_q;
        logic [CACHE_W-1:0] cache_b_q;
        logic [VALUE_W-1:0] ring_q [POOL_DEPTH];
        int unsigned        pos_q;
        pool_result_t       expected_q [$];
        int                 mismatches;
        int                 results_seen;
        int                 op_count [4];

        function new();
            seed_a_q = SEED_A_RESET;
            seed_b_q = SEED_B_RESET;
            cache_a_q = '0;
            cache_b_q = '0;
            foreach (ring_q[k]) ring_q[k] = '0;
            pos_q = 0;
            mismatches = 0;
            results_seen = 0;
            foreach (op_count[k]) op_count[k] = 0;
        endfunction

        // 31 shift steps, feedback bit0 ^ bit4 lands in bit30
        function logic [SEED_W-1:0] advance_seed(logic [SEED_W-1:0] s);
            logic fb;
            for (int k = 0; k < LFSR_STEPS; k++) begin
                fb = s[0] ^ s[4];
                s = s >> 1;
                if (fb) s[TOP_BIT] = 1'b1;
            end
            return s;
        endfunction

        function void refresh();
            cache_a_q = seed_a_q[CACHE_W-1:0];
            cache_b_q = seed_b_q[CACHE_W-1:0];
        endfunction

        function void push_value();
            ring_q[pos_q] = cache_a_q[VALUE_W-1:0];
            pos_q = (pos_q + 1) % POOL_DEPTH;
            seed_a_q = advance_seed(seed_a_q);
            seed_b_q = advance_seed(seed_b_q);
            refresh();
        endfunction

        function void note_request(logic [OP_W-1:0] op, logic [SEED_W-1:0] new_a,
                                   logic [SEED_W-1:0] new_b, logic [OFFSET_W-1:0] off);
            pool_result_t r;
            r.pool_value = '0;
            op_count[op]++;
            case (op)
                OP_NEXT: begin
                    push_value();
                end
                OP_FILL: begin
                    pos_q = 0;
                    for (int k = 0; k < POOL_DEPTH; k++) push_value();
                end
                OP_LOAD: begin
                    seed_a_q = new_a;
                    seed_b_q = new_b;
                    refresh();
                end
                default: begin
                    r.pool_value = ring_q[(pos_q + off) % POOL_DEPTH];
                end
            endcase
            r.rand_a = cache_a_q;
            r.rand_b = cache_b_q;
            r.pool_pos = pos_q[6:0];
            expected_q.push_back(r);
        endfunction

        function void check_result(logic [M_DATA_W-1:0] data);
            pool_result_t exp_r;
            pool_result_t got;
            got.rand_a = data[14:0];
            got.rand_b = data[29:15];
            got.pool_value = data[36:30];
            got.pool_pos = data[43:37];
            results_seen++;
            if (expected_q.size() == 0) begin
                $error("result with no item pending: data 0x%0h", data);
                mismatches++;
                return;
            end
            exp_r = expected_q.pop_front();
            if (got.rand_a !== exp_r.rand_a) begin
                $error("rand_a: expected 0x%0h, got 0x%0h", exp_r.rand_a, got.rand_a);
                mismatches++;
            end
            if (got.rand_b !== exp_r.rand_b) begin
                $error("rand_b: expected 0x%0h, got 0x%0h", exp_r.rand_b, got.rand_b);
                mismatches++;
            end
            if (got.pool_value !== exp_r.pool_value) begin
                $error("pool_value: expected %0d, got %0d", exp_r.pool_value, got.pool_value);
                mismatches++;
            end
            if (got.pool_pos !== exp_r.pool_pos) begin
                $error("pool_pos: expected %0d, got %0d", exp_r.pool_pos, got.pool_pos);
                mismatches++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_s_tvalid = 1'b0;
    logic                o_s_tready;
    // [31:0] seed_a, [63:32] seed_b, [70:64] offset, [71] zero
    logic [S_DATA_W-1:0] i_s_tdata = '0;
    // [1:0] op
    logic [OP_W-1:0]     i_s_tuser = OP_NEXT;
    logic                o_m_tvalid;
    logic                i_m_tready = 1'b0;
    // [14:0] rand_a, [29:15] rand_b, [36:30] pool_value, [43:37] pool_pos, [47:44] zero
    logic [M_DATA_W-1:0] o_m_tdata;

    pool_scoreboard sb = new();

    int rx_cycle = 0;
    int stall_left = 0;
    int stall_pct = 0;
    int fills_sent = 0;

    dual_lfsr_random_pool_unit uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && i_s_tvalid && o_s_tready) begin
            sb.note_request(i_s_tuser, i_s_tdata[31:0], i_s_tdata[63:32], i_s_tdata[70:64]);
        end
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            sb.check_result(o_m_tdata);
        end
    end

    // receiver: stall rate is redrawn from time to time, from none to heavy
    always @(posedge i_clk) begin
        rx_cycle++;
        if (rx_cycle % 150 == 0) begin
            case ($urandom_range(0, 3))
                0: stall_pct = 0;
                1: stall_pct = 15;
                2: stall_pct = 40;
                default: stall_pct = 75;
            endcase
        end
        if (stall_left > 0) begin
            i_m_tready <= 1'b0;
            stall_left--;
        end else begin
            i_m_tready <= 1'b1;
            if ($urandom_range(0, 99) < stall_pct) stall_left = $urandom_range(1, 7);
        end
    end

    task automatic send_item(logic [OP_W-1:0] op, logic [SEED_W-1:0] new_a,
                             logic [SEED_W-1:0] new_b, logic [OFFSET_W-1:0] off);
        i_s_tvalid <= 1'b1;
        i_s_tuser <= op;
        i_s_tdata <= {1'b0, off, new_b, new_a};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
    endtask

    task automatic idle_gap(int n);
        if (n > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // unused seed fields of every item still carry random bits
    task automatic send_simple(logic [OP_W-1:0] op, logic [OFFSET_W-1:0] off);
        send_item(op, $urandom, $urandom, off);
        idle_gap($urandom_range(0, 2));
    endtask

    task automatic send_load(logic [SEED_W-1:0] new_a, logic [SEED_W-1:0] new_b);
        send_item(OP_LOAD, new_a, new_b, OFFSET_W'($urandom));
        idle_gap($urandom_range(0, 2));
    endtask

    task automatic send_random_item();
        int pick;
        logic [OP_W-1:0] op;
        logic [SEED_W-1:0] new_a;
        logic [SEED_W-1:0] new_b;
        pick = $urandom_range(0, 99);
        new_a = $urandom;
        new_b = $urandom;
        if (pick < 45) op = OP_NEXT;
        else if (pick < 80) op = OP_READ;
        else if (pick < 97) op = OP_LOAD;
        else if (fills_sent < 40) op = OP_FILL;
        else op = OP_NEXT;
        if (op == OP_FILL) fills_sent++;
        // occasional degenerate seeds
        if (op == OP_LOAD && $urandom_range(0, 19) == 0) begin
            new_a = $urandom_range(0, 1) ? '0 : '1;
            new_b = $urandom_range(0, 1) ? '0 : 32'h8000_0000;
        end
        send_item(op, new_a, new_b, OFFSET_W'($urandom));
    endtask

    initial begin
        int burst;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset pool and caches, read wrap, seed corners, fill wrap
        send_simple(OP_READ, 7'd0);
        send_simple(OP_READ, 7'd127);
        send_simple(OP_NEXT, 7'd0);
        send_simple(OP_NEXT, 7'd0);
        send_simple(OP_READ, 7'd126);
        send_simple(OP_READ, 7'd127);
        send_load(32'hffff_ffff, 32'hffff_ffff);
        send_simple(OP_NEXT, 7'd0);
        send_load(32'h0000_0000, 32'h0000_0000);
        send_simple(OP_NEXT, 7'd0);
        send_load(32'h8000_0000, 32'h8000_0010);
        send_simple(OP_NEXT, 7'd0);
        send_load(32'h7fff_ffff, 32'h0000_0001);
        send_simple(OP_NEXT, 7'd0);
        send_simple(OP_FILL, 7'd0);
        send_simple(OP_READ, 7'd0);
        send_simple(OP_READ, 7'd127);
        send_simple(OP_READ, 7'd64);
        send_simple(OP_NEXT, 7'd0);
        send_simple(OP_READ, 7'd127);
        send_load($urandom, $urandom);
        send_simple(OP_READ, OFFSET_W'($urandom));

        // random bursts, some of them long with no gaps
        for (int n = 0; n < 1900; n += burst) begin
            burst = $urandom_range(0, 4) == 0 ? $urandom_range(20, 60) : $urandom_range(1, 12);
            for (int k = 0; k < burst; k++) send_random_item();
            idle_gap($urandom_range(1, 9));
        end
        i_s_tvalid <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        $display("covered %0d next, %0d fill, %0d load and %0d read items",
                 sb.op_count[OP_NEXT], sb.op_count[OP_FILL],
                 sb.op_count[OP_LOAD], sb.op_count[OP_READ]);
        $display("%0d results compared, %0d field mismatches", sb.results_seen, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("[dual_lfsr_random_pool_unit] OK");
        end else begin
            $display("[dual_lfsr_random_pool_unit] ERROR");
        end
        $finish;
    end

    initial begin
        #8_000_000;
        $display("timeout with %0d results still pending", sb.pending());
        $display("[dual_lfsr_random_pool_unit] ERROR");
        $finish;
    end

endmodule
